>>> rtl/core/slip_deframer_crc_check_top_assert.svh
// Assertion macros for the SLIP deframer with CRC check.
// Each macro expands to one labelled concurrent assertion clocked on clk
// and held off while rst is high.
`ifndef SLIP_DEFRAMER_CRC_CHECK_TOP_ASSERT_SVH
`define SLIP_DEFRAMER_CRC_CHECK_TOP_ASSERT_SVH

// Same-cycle implication
`define SDCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sdcc_pkg.sv
// ----------------------------------------------------------------------------
// sdcc_pkg
// Shared types, constants and the CRC-16/XMODEM byte fold for the SLIP
// deframer with CRC check.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcc_pkg;

  // SLIP framing bytes
  localparam logic [7:0] FLAG_END     = 8'hC0;
  localparam logic [7:0] FLAG_ESC     = 8'hDB;
  localparam logic [7:0] FLAG_ESC_END = 8'hDC;

  // Defaults and sizes
  localparam int          MAX_FRAME_DEF = 1024;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam int          QUEUE_DEPTH   = 2;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command classes handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_END  = 2'd1,
    CMD_ESC  = 2'd2,
    CMD_DATA = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] rx_byte;
  } cmd_t;

  // Result kind codes
  typedef enum logic [1:0] {
    RES_DATA    = 2'd0,
    RES_END     = 2'd1,
    RES_TIMEOUT = 2'd2
  } res_kind_t;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_OVERFLOW = 2'd2
  } frame_status_t;

  // Back end state flags, watched at the top level
  typedef struct packed {
    logic in_frame;
    logic overflowed;
    logic count_nonzero;
  } back_status_t;

  // CRC-16/XMODEM, MSB first, one byte
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sdcc_if.sv
// ----------------------------------------------------------------------------
// sdcc_if
// Valid/ready channel interfaces: line input, decoded results and the
// timeout configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdcc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sdcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [10:0] frame_length;
  logic [1:0]  frame_status;
  modport source (output valid, output result_kind, output data_byte,
                  output frame_length, output frame_status, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input frame_length, input frame_status, output ready);
endinterface

interface sdcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;
  modport source (output valid, output timeout_ticks, input ready);
  modport sink   (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sdcc_front.sv
// ----------------------------------------------------------------------------
// sdcc_front
// Accepts line beats, classifies them as tick, frame end, escape or data,
// and holds the classified command in a register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  sdcc_in_if.sink            rx,
  output sdcc_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);

  logic           hold_valid;
  logic           hold_valid_next;
  sdcc_pkg::cmd_t hold_cmd;
  sdcc_pkg::cmd_t class_cmd;
  logic           rx_acc;

  // Take a new beat whenever the hold register is empty or draining
  assign rx.ready = !hold_valid || cmd_ready;
  assign rx_acc   = rx.valid && rx.ready;

  // Classify the incoming beat
  always_comb begin
    class_cmd.rx_byte = rx.rx_byte;
    if (rx.opcode == sdcc_pkg::OP_TICK) begin
      class_cmd.kind = sdcc_pkg::CMD_TICK;
    end else if (rx.rx_byte == sdcc_pkg::FLAG_END) begin
      class_cmd.kind = sdcc_pkg::CMD_END;
    end else if (rx.rx_byte == sdcc_pkg::FLAG_ESC) begin
      class_cmd.kind = sdcc_pkg::CMD_ESC;
    end else begin
      class_cmd.kind = sdcc_pkg::CMD_DATA;
    end
  end

  always_comb begin
    if (rx_acc) begin
      hold_valid_next = 1'b1;
    end else if (cmd_ready) begin
      hold_valid_next = 1'b0;
    end else begin
      hold_valid_next = hold_valid;
    end
  end

  // Hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_acc) begin
      hold_cmd <= class_cmd;
    end
  end

  assign cmd       = hold_cmd;
  assign cmd_valid = hold_valid;

endmodule

`default_nettype wire

>>> rtl/core/sdcc_queue.sv
// ----------------------------------------------------------------------------
// sdcc_queue
// Short command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sdcc_pkg::cmd_t push_cmd,
  input  wire logic           push,
  output logic                full,
  output sdcc_pkg::cmd_t      pop_cmd,
  output logic                not_empty,
  input  wire logic           pop
);

  localparam int DEPTH = sdcc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sdcc_pkg::cmd_t   store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sdcc_back.sv
// ----------------------------------------------------------------------------
// sdcc_back
// Executes queued commands: escape resolution, frame length, CRC fold,
// overflow, tick timeout; registers the result beat for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcc_back #(
  parameter int MAX_FRAME = sdcc_pkg::MAX_FRAME_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sdcc_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  input  wire logic [15:0]    timeout_ticks,
  output sdcc_pkg::back_status_t status,
  sdcc_out_if.source          res
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  // Decoder state
  logic             in_frame,       in_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] byte_count,     byte_count_next;
  logic [15:0]      crc_register,   crc_register_next;
  logic [15:0]      tick_count,     tick_count_next;
  logic             overflowed,     overflowed_next;

  // Result register
  logic        out_valid, out_valid_next;
  logic [1:0]  out_kind;
  logic [7:0]  out_data;
  logic [10:0] out_len;
  logic [1:0]  out_stat;

  logic                    has_res;
  sdcc_pkg::res_kind_t     r_kind;
  logic [7:0]              r_data;
  logic [10:0]             r_len;
  sdcc_pkg::frame_status_t r_stat;
  logic [15:0]             tick_inc;
  logic [7:0]              dec;

  // Pop when the result register is free or being drained
  assign cmd_pop  = cmd_valid && (!out_valid || res.ready);
  assign tick_inc = tick_count + 16'd1;

  // Resolve an escaped byte
  always_comb begin
    if (escape_pending) begin
      dec = (cmd.rx_byte == sdcc_pkg::FLAG_ESC_END) ? sdcc_pkg::FLAG_END
                                                    : sdcc_pkg::FLAG_ESC;
    end else begin
      dec = cmd.rx_byte;
    end
  end

  // Command execution
  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    byte_count_next     = byte_count;
    crc_register_next   = crc_register;
    tick_count_next     = tick_count;
    overflowed_next     = overflowed;
    has_res             = 1'b0;
    r_kind              = sdcc_pkg::RES_DATA;
    r_data              = 8'h00;
    r_len               = 11'd0;
    r_stat              = sdcc_pkg::ST_GOOD;
    if (cmd_pop) begin
      case (cmd.kind)
        sdcc_pkg::CMD_TICK: begin
          if (tick_inc >= timeout_ticks) begin
            // timeout: full restart
            in_frame_next       = 1'b0;
            escape_pending_next = 1'b0;
            byte_count_next     = '0;
            crc_register_next   = 16'h0000;
            tick_count_next     = 16'h0000;
            overflowed_next     = 1'b0;
            has_res             = 1'b1;
            r_kind              = sdcc_pkg::RES_TIMEOUT;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        sdcc_pkg::CMD_END: begin
          has_res = 1'b1;
          r_kind  = sdcc_pkg::RES_END;
          r_len   = 11'(byte_count);
          if (overflowed) begin
            r_stat = sdcc_pkg::ST_OVERFLOW;
          end else if (crc_register != 16'h0000) begin
            r_stat = sdcc_pkg::ST_CRC_ERR;
          end
          in_frame_next       = 1'b0;
          escape_pending_next = 1'b0;
          byte_count_next     = '0;
          crc_register_next   = 16'h0000;
          overflowed_next     = 1'b0;
        end
        sdcc_pkg::CMD_ESC: begin
          escape_pending_next = 1'b1;
        end
        sdcc_pkg::CMD_DATA: begin
          if (!in_frame) begin
            tick_count_next = 16'h0000;
            in_frame_next   = 1'b1;
          end
          escape_pending_next = 1'b0;
          if (byte_count >= CNT_W'(MAX_FRAME)) begin
            overflowed_next = 1'b1;
          end else begin
            crc_register_next = sdcc_pkg::crc16_fold(crc_register, dec);
            byte_count_next   = byte_count + CNT_W'(1);
            has_res           = 1'b1;
            r_data            = dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (has_res) begin
      out_valid_next = 1'b1;
    end else if (res.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      crc_register   <= 16'h0000;
      tick_count     <= 16'h0000;
      overflowed     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
      crc_register   <= crc_register_next;
      tick_count     <= tick_count_next;
      overflowed     <= overflowed_next;
      out_valid      <= out_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (has_res) begin
      out_kind <= r_kind;
      out_data <= r_data;
      out_len  <= r_len;
      out_stat <= r_stat;
    end
  end

  assign res.valid        = out_valid;
  assign res.result_kind  = out_kind;
  assign res.data_byte    = out_data;
  assign res.frame_length = out_len;
  assign res.frame_status = out_stat;

  assign status.in_frame      = in_frame;
  assign status.overflowed    = overflowed;
  assign status.count_nonzero = (byte_count != '0);

endmodule

`default_nettype wire

>>> rtl/core/slip_deframer_crc_check_top.sv
// ----------------------------------------------------------------------------
// slip_deframer_crc_check_top
// SLIP frame decoder with streamed payload, CRC-16/XMODEM frame check,
// overflow flagging and a tick-driven restart timeout.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  rx      | in  | valid/ready | opcode, rx_byte
//  res     | out | valid/ready | result_kind, data_byte, frame_length,
//          |     |             | frame_status
//  cfg     | in  | valid/ready | timeout_ticks (always ready)
//
//  One beat a cycle sustained while res is not stalled; a beat's result passes
//  through the hold register, queue and result register. The byte CRC fold
//  sets the back end's path; it executes one command a cycle unless res stalls.
//  Reset (rst, synchronous) clears the decoder and loads timeout_ticks = 1000.
//  A stall on res fills the two-entry queue and the hold register, then
//  drops rx.ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slip_deframer_crc_check_top_assert.svh"

module slip_deframer_crc_check_top #(
  parameter int MAX_FRAME = sdcc_pkg::MAX_FRAME_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sdcc_cfg_if.sink   cfg,
  sdcc_in_if.sink    rx,
  sdcc_out_if.source res
);

  logic                   [15:0] timeout_ticks;
  sdcc_pkg::cmd_t         front_cmd;
  logic                   front_valid;
  logic                   q_full;
  sdcc_pkg::cmd_t         q_cmd;
  logic                   q_valid;
  logic                   q_pop;
  sdcc_pkg::back_status_t back_st;
  logic                   res_ovf_end;
  logic                   end_pop;
  logic                   state_idle;
  logic                   [10:0] max_len;

  // Timeout register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= sdcc_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ticks <= cfg.timeout_ticks;
    end
  end

  // Front end
  sdcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (!q_full)
  );

  // Command queue
  sdcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cmd  (front_cmd),
    .push      (front_valid),
    .full      (q_full),
    .pop_cmd   (q_cmd),
    .not_empty (q_valid),
    .pop       (q_pop)
  );

  // Back end
  sdcc_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (q_cmd),
    .cmd_valid     (q_valid),
    .cmd_pop       (q_pop),
    .timeout_ticks (timeout_ticks),
    .status        (back_st),
    .res           (res)
  );

  // Terms watched by the checks
  assign res_ovf_end = res.valid && (res.result_kind == sdcc_pkg::RES_END) &&
                       (res.frame_status == sdcc_pkg::ST_OVERFLOW);
  assign end_pop     = q_pop && (q_cmd.kind == sdcc_pkg::CMD_END);
  assign state_idle  = !back_st.in_frame && !back_st.count_nonzero;
  assign max_len     = 11'(MAX_FRAME);

  // Checks
  `SDCC_ASSERT_NOW(a_ovf_in_frame, back_st.overflowed, back_st.in_frame, "overflow outside frame")
  `SDCC_ASSERT_NOW(a_cnt_in_frame, back_st.count_nonzero, back_st.in_frame, "bytes outside frame")
  `SDCC_ASSERT_NOW(a_ovf_len, res_ovf_end, res.frame_length == max_len, "overflow length wrong")
  `SDCC_ASSERT_NEXT(a_end_clears, end_pop, state_idle, "frame end left state")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SLIP deframer with CRC-16/XMODEM check. Line
// beats and timeout ticks go in through a queue-fed driver; a clocked monitor
// compares every result beat against a cycle-free decoder kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int         FRAME_CAP    = sdcc_pkg::MAX_FRAME_DEF;
  localparam logic [7:0] LINE_ESC_ESC = 8'hDD;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } line_beat_t;

  typedef struct {
    sdcc_pkg::res_kind_t     kind;
    logic [7:0]              data;
    logic [10:0]             len;
    sdcc_pkg::frame_status_t status;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  sdcc_cfg_if cfg ();
  sdcc_in_if  rx ();
  sdcc_out_if res ();

  slip_deframer_crc_check_top #(
    .MAX_FRAME(FRAME_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .rx (rx),
    .res(res)
  );

  // Stimulus and expectation stores
  line_beat_t line_q[$];
  decoded_t   decoded_q[$];
  int         pushed       = 0;
  int         errors       = 0;
  int         tx_idle_pct  = 0;
  int         rx_stall_pct = 0;

  // Decoder state mirrored in the bench
  logic [15:0] limit_ticks = sdcc_pkg::TIMEOUT_RESET;
  logic        mdl_in_frame = 1'b0;
  logic        mdl_escape   = 1'b0;
  logic [10:0] mdl_count    = '0;
  logic [15:0] mdl_crc      = '0;
  logic [15:0] mdl_ticks    = '0;
  logic        mdl_overflow = 1'b0;

  // CRC-16/XMODEM, MSB first, poly 0x1021
  function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] acc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    repeat (8) begin
      if (c[15]) c = (c << 1) ^ 16'h1021;
      else       c = c << 1;
    end
    return c;
  endfunction

  // Advance the mirrored decoder by one accepted beat
  function automatic void decode_step(input logic op, input logic [7:0] b);
    logic [7:0] dec;
    decoded_t   r;
    r.kind   = sdcc_pkg::RES_DATA;
    r.data   = '0;
    r.len    = '0;
    r.status = sdcc_pkg::ST_GOOD;
    if (op == sdcc_pkg::OP_TICK) begin
      mdl_ticks = mdl_ticks + 16'd1;
      if (mdl_ticks >= limit_ticks) begin
        mdl_in_frame = 1'b0;
        mdl_escape   = 1'b0;
        mdl_count    = '0;
        mdl_crc      = '0;
        mdl_ticks    = '0;
        mdl_overflow = 1'b0;
        r.kind       = sdcc_pkg::RES_TIMEOUT;
        decoded_q.push_back(r);
      end
    end else if (b == sdcc_pkg::FLAG_END) begin
      r.kind = sdcc_pkg::RES_END;
      r.len  = mdl_count;
      if (mdl_overflow)        r.status = sdcc_pkg::ST_OVERFLOW;
      else if (mdl_crc == '0)  r.status = sdcc_pkg::ST_GOOD;
      else                     r.status = sdcc_pkg::ST_CRC_ERR;
      decoded_q.push_back(r);
      // tick count survives a frame end
      mdl_in_frame = 1'b0;
      mdl_escape   = 1'b0;
      mdl_count    = '0;
      mdl_crc      = '0;
      mdl_overflow = 1'b0;
    end else if (b == sdcc_pkg::FLAG_ESC) begin
      mdl_escape = 1'b1;
    end else begin
      if (!mdl_in_frame) begin
        mdl_ticks    = '0;
        mdl_in_frame = 1'b1;
      end
      if (mdl_escape) dec = (b == sdcc_pkg::FLAG_ESC_END) ? sdcc_pkg::FLAG_END
                                                          : sdcc_pkg::FLAG_ESC;
      else            dec = b;
      mdl_escape = 1'b0;
      if (mdl_count >= FRAME_CAP) begin
        mdl_overflow = 1'b1;
      end else begin
        mdl_crc   = crc_xmodem_byte(mdl_crc, dec);
        mdl_count = mdl_count + 11'd1;
        r.data    = dec;
        decoded_q.push_back(r);
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("t=%0t mismatch: %s", $time, what);
    errors++;
  endtask

  // Driver: offers the next pending beat, predicts on acceptance
  always @(posedge clk) begin : line_driver
    line_beat_t nxt;
    if (rst) begin
      rx.valid <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) decode_step(rx.opcode, rx.rx_byte);
      if (!rx.valid || rx.ready) begin
        if (line_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = line_q.pop_front();
          rx.valid   <= 1'b1;
          rx.opcode  <= nxt.op;
          rx.rx_byte <= nxt.b;
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction
  always @(posedge clk) begin : result_monitor
    decoded_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with none pending", res.result_kind));
        end else begin
          want = decoded_q.pop_front();
          if (res.result_kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, want %0d",
                                      res.result_kind, want.kind));
          if (res.data_byte !== want.data)
            report_mismatch($sformatf("data_byte %02h, want %02h",
                                      res.data_byte, want.data));
          if (res.frame_length !== want.len)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      res.frame_length, want.len));
          if (res.frame_status !== want.status)
            report_mismatch($sformatf("frame_status %0d, want %0d",
                                      res.frame_status, want.status));
        end
      end
      res.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_line(input logic op, input logic [7:0] b);
    line_q.push_back('{op, b});
    pushed++;
  endtask

  // SLIP-encode one decoded byte
  task automatic push_coded(input logic [7:0] d);
    if (d == sdcc_pkg::FLAG_END) begin
      push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
      push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC_END);
    end else if (d == sdcc_pkg::FLAG_ESC) begin
      push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
      push_line(sdcc_pkg::OP_BYTE, LINE_ESC_ESC);
    end else begin
      push_line(sdcc_pkg::OP_BYTE, d);
    end
  endtask

  // Payload byte drawn only from the framing codes, for pick_byte's bias
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(3))
      0: return sdcc_pkg::FLAG_END;
      1: return sdcc_pkg::FLAG_ESC;
      2: return sdcc_pkg::FLAG_ESC_END;
      default: return LINE_ESC_ESC;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) == 0) return pick_payload();
    return 8'($urandom);
  endfunction

  // Frame of payload, CRC high then low, end flag; corrupt flips one bit
  task automatic send_frame(input int n, input bit corrupt, input int tick_pct);
    logic [7:0]  body[$];
    logic [15:0] acc;
    int          k;
    acc = '0;
    if ($urandom_range(1)) push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
    for (k = 0; k < n; k++) begin
      body.push_back(pick_byte());
      acc = crc_xmodem_byte(acc, body[k]);
    end
    body.push_back(acc[15:8]);
    body.push_back(acc[7:0]);
    if (corrupt) begin
      k = $urandom_range(body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(7));
    end
    foreach (body[i]) begin
      if ($urandom_range(99) < tick_pct) push_line(sdcc_pkg::OP_TICK, 8'($urandom));
      push_coded(body[i]);
    end
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
  endtask

  // Mostly good frames, some damaged ones, ticks and line noise
  task automatic random_phase(input int budget);
    int stop;
    stop = pushed + budget;
    while (pushed < stop) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
          send_frame($urandom_range(0, 10), 1'b0, 4);
        11, 12:
          send_frame($urandom_range(0, 10), 1'b1, 4);
        13, 14:
          repeat ($urandom_range(1, 6)) push_line(1'($urandom), 8'($urandom));
        15, 16:
          repeat ($urandom_range(1, 10)) push_line(sdcc_pkg::OP_TICK, 8'($urandom));
        17: begin
          push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
          push_line(sdcc_pkg::OP_BYTE, pick_byte());
        end
        18: begin
          push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
          push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
        end
        default:
          repeat ($urandom_range(1, 5)) push_coded(pick_byte());
      endcase
    end
  endtask

  // Drain everything, then let the pipeline settle
  task automatic wait_idle();
    while (line_q.size() != 0 || rx.valid || decoded_q.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg.valid         <= 1'b1;
    cfg.timeout_ticks <= v;
    do @(posedge clk); while (!cfg.ready);
    limit_ticks = v;
    cfg.valid  <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] acc;
    cfg.valid         = 1'b0;
    cfg.timeout_ticks = '0;
    rx.valid          = 1'b0;
    rx.opcode         = sdcc_pkg::OP_BYTE;
    rx.rx_byte        = '0;
    res.ready         = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty end, extreme payload, escapes, reset limit
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
    acc = crc_xmodem_byte(crc_xmodem_byte(16'h0000, 8'h00), 8'hFF);
    push_line(sdcc_pkg::OP_BYTE, 8'h00);
    push_line(sdcc_pkg::OP_BYTE, 8'hFF);
    push_coded(acc[15:8]);
    push_coded(acc[7:0]);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
    // escape dropped by end flag
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
    // repeated escape, bad escape, plain escaped escape
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC_END);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
    push_line(sdcc_pkg::OP_BYTE, 8'h41);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_ESC);
    push_line(sdcc_pkg::OP_BYTE, LINE_ESC_ESC);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
    push_line(sdcc_pkg::OP_TICK, 8'hFF);
    wait_idle();

    // Zero limit restarts on the first tick
    write_limit(16'd0);
    push_line(sdcc_pkg::OP_TICK, 8'h00);
    wait_idle();

    // Frame start clears ticks, frame end keeps them
    write_limit(16'd3);
    push_line(sdcc_pkg::OP_BYTE, 8'h55);
    push_line(sdcc_pkg::OP_TICK, 8'hAA);
    push_line(sdcc_pkg::OP_BYTE, sdcc_pkg::FLAG_END);
    push_line(sdcc_pkg::OP_TICK, 8'h0F);
    push_line(sdcc_pkg::OP_TICK, 8'hF0);
    wait_idle();

    // Random phases over several limits and idling patterns
    write_limit(16'd0);
    random_phase(80);
    wait_idle();

    tx_idle_pct = 73;
    write_limit(16'd6);
    random_phase(150);
    wait_idle();

    tx_idle_pct  = 0;
    rx_stall_pct = 73;
    write_limit(16'hFFFF);
    send_frame(1030, 1'b0, 0);
    random_phase(60);
    wait_idle();

    tx_idle_pct  = 6;
    rx_stall_pct = 6;
    write_limit(16'd1);
    random_phase(120);
    wait_idle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #800000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/sdcc_pkg.sv
rtl/core/sdcc_if.sv
rtl/core/sdcc_front.sv
rtl/core/sdcc_queue.sv
rtl/core/sdcc_back.sv
rtl/core/slip_deframer_crc_check_top.sv
test/tb_top.sv
